// ===== hw/rtl/factor_crossproduct_accumulator_assert.svh =====
// assertion macros for the cross-product accumulator
`ifndef FACTOR_CROSSPRODUCT_ACCUMULATOR_ASSERT_SVH
`define FACTOR_CROSSPRODUCT_ACCUMULATOR_ASSERT_SVH
// implication checked at every edge outside reset
`define FCA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define FCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/fca_pkg.sv =====
// shared types and constants of the cross-product accumulator
`default_nettype none
package fca_pkg;
  localparam int MAX_MATRIX = 64;
  localparam int MAP_DEPTH = 1024;
  localparam int MAX_LEVEL_DIMS = 2;
  localparam int STORE_DEPTH = MAX_MATRIX * MAX_MATRIX;
  localparam int SA_W = $clog2(STORE_DEPTH);
  localparam int MA_W = $clog2(MAP_DEPTH);

  localparam logic [2:0] ACT_ACC = 3'd0;
  localparam logic [2:0] ACT_ROWMAP = 3'd1;
  localparam logic [2:0] ACT_COLMAP = 3'd2;
  localparam logic [2:0] ACT_READ = 3'd3;
  localparam logic [2:0] ACT_WRITE = 3'd4;

  localparam logic [2:0] ST_DONE = 3'd0;
  localparam logic [2:0] ST_MISSING = 3'd1;
  localparam logic [2:0] ST_NOEST = 3'd2;
  localparam logic [2:0] ST_BADMODE = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;
  localparam logic [2:0] ST_SAT = 3'd5;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_ROW_DIMS = 3'd1;
  localparam logic [2:0] REG_COL_DIMS = 3'd2;
  localparam logic [2:0] REG_ROW_STRIDE = 3'd3;
  localparam logic [2:0] REG_COL_STRIDE = 3'd4;
  localparam logic [2:0] REG_ROW_OFFSET = 3'd5;
  localparam logic [2:0] REG_COL_OFFSET = 3'd6;
  localparam logic [2:0] REG_MATRIX_SIZE = 3'd7;

  localparam logic signed [47:0] QMAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] QMIN = 48'sh8000_0000_0000;
  localparam logic signed [47:0] ONE_Q = 48'sd65536;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch input item, start map reads
    logic check;     // evaluate lookups, start store read
    logic mul;       // run one multiply step
    logic [1:0] mul_sel;  // 0 weight, 1 row cov, 2 col cov
    logic sum;       // add product to store entry
    logic commit;    // write store and load result
    logic clr_step;  // clearing pass write
  } fca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_acc;      // item is a valid accumulate
    logic [2:0] mode;
    logic clr_last;
  } fca_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/fca_ctrl.sv =====
// controller state machine of the cross-product accumulator
`default_nettype none
module fca_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  wire logic out_ready,
  input  wire fca_pkg::fca_stat_t stat,
  output fca_pkg::fca_cmd_t cmd
);
  import fca_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_CHECK, S_MUL0, S_MUL1, S_MUL2, S_SUM, S_COMMIT
  } state_t;
  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_next = S_LOOK;
        end
      end
      // map entries are read at the end of this cycle
      S_LOOK: state_next = S_CHECK;
      S_CHECK: begin
        cmd.check = 1'b1;
        state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul = stat.is_acc && stat.mode[0];
        cmd.mul_sel = 2'd0;
        state_next = stat.is_acc ? S_MUL1 : S_COMMIT;
      end
      S_MUL1: begin
        cmd.mul = stat.mode[1];
        cmd.mul_sel = 2'd1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul = stat.mode[2];
        cmd.mul_sel = 2'd2;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        // wait here while the previous result is still stalled
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/fca_datapath.sv =====
// datapath of the cross-product accumulator: maps, store, multiplier, adder
`default_nettype none
module fca_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire fca_pkg::fca_cmd_t cmd,
  output fca_pkg::fca_stat_t stat,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_data,
  input  wire logic [2:0] action,
  input  wire logic signed [31:0] weight,
  input  wire logic signed [31:0] row_cov,
  input  wire logic signed [31:0] col_cov,
  input  wire logic [2:0] valid_mask,
  input  wire logic [9:0] row_sub_a,
  input  wire logic [9:0] row_sub_b,
  input  wire logic [9:0] col_sub_a,
  input  wire logic [9:0] col_sub_b,
  input  wire logic [11:0] table_address,
  input  wire logic signed [47:0] table_data,
  output logic signed [47:0] read_data,
  output logic [2:0] status
);
  import fca_pkg::*;

  // configuration
  logic [2:0] mode;
  logic [1:0] row_dims, col_dims;
  logic [9:0] row_stride, col_stride;
  logic [5:0] row_offset, col_offset;
  logic [6:0] matrix_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 3'd0; row_dims <= 2'd1; col_dims <= 2'd1;
      row_stride <= 10'd1; col_stride <= 10'd1;
      row_offset <= 6'd0; col_offset <= 6'd0; matrix_size <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE: mode <= cfg_data[2:0];
        REG_ROW_DIMS: row_dims <= cfg_data[1:0];
        REG_COL_DIMS: col_dims <= cfg_data[1:0];
        REG_ROW_STRIDE: row_stride <= cfg_data;
        REG_COL_STRIDE: col_stride <= cfg_data;
        REG_ROW_OFFSET: row_offset <= cfg_data[5:0];
        REG_COL_OFFSET: col_offset <= cfg_data[5:0];
        REG_MATRIX_SIZE: matrix_size <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic [7:0] size;
  always_comb begin
    if (matrix_size == 7'd0) size = 8'd1;
    else if ({1'b0, matrix_size} > 8'(MAX_MATRIX)) size = 8'(MAX_MATRIX);
    else size = {1'b0, matrix_size};
  end

  // captured item
  logic [2:0] act_q, vm_q;
  logic signed [31:0] w_q, rc_q, cc_q;
  logic [11:0] addr_q;
  logic signed [47:0] data_q;
  logic [20:0] rix, cix;

  logic [20:0] rix_next, cix_next;
  always_comb begin
    rix_next = (row_dims == 2'd2) ? 21'(row_sub_a) + 21'(row_sub_b) * 21'(row_stride)
                                  : 21'(row_sub_a);
    cix_next = (col_dims == 2'd2) ? 21'(col_sub_a) + 21'(col_sub_b) * 21'(col_stride)
                                  : 21'(col_sub_a);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action; vm_q <= valid_mask;
      w_q <= weight; rc_q <= row_cov; cc_q <= col_cov;
      addr_q <= table_address; data_q <= table_data;
      rix <= rix_next; cix <= cix_next;
    end
  end

  // level maps, registered read
  logic [7:0] row_map [MAP_DEPTH];
  logic [7:0] col_map [MAP_DEPTH];
  logic [7:0] rmap_q, cmap_q;
  logic map_we;
  assign map_we = cmd.commit && (addr_q < 12'(MAP_DEPTH));
  always_ff @(posedge clk) begin
    if (map_we && act_q == ACT_ROWMAP) row_map[addr_q[MA_W-1:0]] <= data_q[7:0];
    rmap_q <= row_map[rix[MA_W-1:0]];
  end
  always_ff @(posedge clk) begin
    if (map_we && act_q == ACT_COLMAP) col_map[addr_q[MA_W-1:0]] <= data_q[7:0];
    cmap_q <= col_map[cix[MA_W-1:0]];
  end

  // accumulate checks, done in the cycle after the map read
  logic bad_mode, missing;
  logic [2:0] acc_st;
  logic [7:0] r_t, c_t;
  logic [15:0] acc_addr, size_sq;
  assign size_sq = 16'(size) * 16'(size);
  always_comb begin
    bad_mode = (row_dims == 2'd3) || (col_dims == 2'd3) ||
               (row_dims == 2'd0 && col_dims == 2'd0) ||
               (row_dims == 2'd0 && !mode[1]) || (col_dims == 2'd0 && !mode[2]);
    missing = |(mode & ~vm_q);
    r_t = 8'(row_offset) + ((row_dims != 2'd0) ? 8'(rmap_q[6:0]) : 8'd0);
    c_t = 8'(col_offset) + ((col_dims != 2'd0) ? 8'(cmap_q[6:0]) : 8'd0);
    if (bad_mode) acc_st = ST_BADMODE;
    else if (missing) acc_st = ST_MISSING;
    else if (row_dims != 2'd0 && rix >= 21'(MAP_DEPTH)) acc_st = ST_RANGE;
    else if (row_dims != 2'd0 && rmap_q[7]) acc_st = ST_NOEST;
    else if (col_dims != 2'd0 && cix >= 21'(MAP_DEPTH)) acc_st = ST_RANGE;
    else if (col_dims != 2'd0 && cmap_q[7]) acc_st = ST_NOEST;
    else if (r_t >= size || c_t >= size) acc_st = ST_RANGE;
    else acc_st = ST_DONE;
    acc_addr = 16'(c_t) * 16'(size) + 16'(r_t);
  end

  // store with clearing pass
  logic signed [47:0] store [STORE_DEPTH];
  logic signed [47:0] store_q;
  logic [SA_W:0] clr_cnt;
  logic [SA_W-1:0] st_addr;
  logic [2:0] st_q;
  logic is_acc;
  logic signed [47:0] prod, sum_q;
  logic sat;

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.clr_step) clr_cnt <= clr_cnt + 1'b1;
  end
  assign stat.clr_last = (clr_cnt == (SA_W+1)'(STORE_DEPTH - 1));
  assign stat.is_acc = is_acc;
  assign stat.mode = mode;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      is_acc <= (act_q == ACT_ACC) && (acc_st == ST_DONE);
      st_addr <= (act_q == ACT_ACC) ? acc_addr[SA_W-1:0] : addr_q[SA_W-1:0];
      unique case (act_q)
        ACT_ACC: st_q <= acc_st;
        ACT_ROWMAP, ACT_COLMAP: st_q <= (addr_q < 12'(MAP_DEPTH)) ? ST_DONE : ST_RANGE;
        ACT_READ, ACT_WRITE: st_q <= (16'(addr_q) < size_sq) ? ST_DONE : ST_RANGE;
        default: st_q <= ST_RANGE;
      endcase
    end
  end

  logic st_we;
  logic [SA_W-1:0] we_addr;
  logic signed [47:0] we_data;
  always_comb begin
    st_we = 1'b0; we_addr = st_addr; we_data = sum_q;
    if (cmd.clr_step) begin
      st_we = 1'b1; we_addr = clr_cnt[SA_W-1:0]; we_data = '0;
    end else if (cmd.commit && st_q == ST_DONE) begin
      if (is_acc) st_we = 1'b1;
      else if (act_q == ACT_WRITE) begin
        st_we = 1'b1; we_data = data_q;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (st_we) store[we_addr] <= we_data;
    store_q <= store[st_addr];
  end

  // multiply step: |prod| by |factor|, rounded half away, saturated
  // upper 32 and lower 16 bits of |prod| go through separate multipliers
  logic signed [31:0] fac;
  logic [47:0] ua;
  logic [31:0] ub;
  logic [63:0] p_hi;
  logic [47:0] p_lo;
  logic [64:0] m;
  logic neg;
  logic signed [47:0] mres;
  logic msat;
  always_comb begin
    unique case (cmd.mul_sel)
      2'd0: fac = w_q;
      2'd1: fac = rc_q;
      default: fac = cc_q;
    endcase
    ua = prod[47] ? 48'(-prod) : prod;
    ub = fac[31] ? 32'(-fac) : fac;
    p_hi = 64'(ua[47:16]) * 64'(ub);
    p_lo = 48'(ua[15:0]) * 48'(ub);
    m = 65'(p_hi) + 65'((p_lo + 48'h8000) >> 16);
    neg = prod[47] ^ fac[31];
    msat = 1'b0;
    if (!neg) begin
      if (m > 65'(QMAX)) begin mres = QMAX; msat = 1'b1; end
      else mres = 48'(m);
    end else begin
      if (m > 65'h8000_0000_0000) begin mres = QMIN; msat = 1'b1; end
      else mres = 48'(-m);
    end
  end

  logic signed [48:0] sum_w;
  assign sum_w = 49'(store_q) + 49'(prod);

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      prod <= ONE_Q; sat <= 1'b0;
    end else if (cmd.mul) begin
      prod <= mres; sat <= sat | msat;
    end else if (cmd.sum) begin
      if (sum_w > 49'(QMAX)) begin sum_q <= QMAX; sat <= 1'b1; end
      else if (sum_w < 49'(QMIN)) begin sum_q <= QMIN; sat <= 1'b1; end
      else sum_q <= 48'(sum_w);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      read_data <= (act_q == ACT_READ && st_q == ST_DONE) ? store_q : '0;
      status <= (is_acc && sat) ? ST_SAT : st_q;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/factor_crossproduct_accumulator.sv =====
// top level of the weighted cross-product scatter accumulator
// flow: one item at a time; the next is accepted only after the map read, the
//   three-step multiply of an accumulate and the write-back of one store entry;
//   a stalled result holds the next write-back until it is taken
// reset: synchronous, then a clearing pass zeroes all 4096 store entries
//   with no item accepted; configuration writes are taken during it
`default_nettype none
module factor_crossproduct_accumulator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_ready,
  input  wire logic [2:0] action,
  input  wire logic signed [31:0] weight,
  input  wire logic signed [31:0] row_cov,
  input  wire logic signed [31:0] col_cov,
  input  wire logic [2:0] valid_mask,
  input  wire logic [9:0] row_sub_a,
  input  wire logic [9:0] row_sub_b,
  input  wire logic [9:0] col_sub_a,
  input  wire logic [9:0] col_sub_b,
  input  wire logic [11:0] table_address,
  input  wire logic signed [47:0] table_data,
  output logic out_valid,
  input  wire logic out_ready,
  output logic signed [47:0] read_data,
  output logic [2:0] status,
  input  wire logic cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [9:0] cfg_data
);
  import fca_pkg::*;

  // command and status between controller and datapath
  fca_cmd_t cmd;
  fca_stat_t stat;

  fca_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .stat, .cmd
  );

  fca_datapath u_dp (
    .clk, .rst, .cmd, .stat, .cfg_we, .cfg_index, .cfg_data,
    .action, .weight, .row_cov, .col_cov, .valid_mask,
    .row_sub_a, .row_sub_b, .col_sub_a, .col_sub_b,
    .table_address, .table_data, .read_data, .status
  );

`include "factor_crossproduct_accumulator_assert.svh"
  // read data is only nonzero on a clean result
  `FCA_ASSERT_IMP(a_rd_zero, clk, rst, out_valid && status != ST_DONE, read_data == '0, "read data on failed item")
  // status stays within its codes
  `FCA_ASSERT_IMP(a_status, clk, rst, out_valid, status <= ST_SAT, "status code out of range")
  // a stalled result keeps its status
  `FCA_ASSERT_NEXT(a_stall, clk, rst, out_valid && !out_ready, $stable(status), "stalled status changed")
  // a stalled result holds
  `FCA_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(read_data), "stalled result changed")
endmodule
`default_nettype wire
